[hw/rtl/psba_pkg.sv]
// Shared types and constants for the page slot bitmap allocator.
// No dependencies; psba_div and the top level import this package.
`default_nettype none

package psba_pkg;

   // Bitmap storage: slots are packed this many to a memory word
   localparam int WORD_BITS = 32;
   localparam int WORD_LG   = 5;

   // Page layout
   localparam int HEADER_BYTES = 9;

   // Register reset values
   localparam int RESET_SLOT_BYTES = 64;
   localparam int RESET_PAGE_KIB   = 64;

   // Slot-count divider: dividend up to (127*1024-9)*8, divisor up to 65535*8+1
   localparam int DIV_W   = 20;
   localparam int DIV_CNT = 5;

   // Request kinds
   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_DROP   = 2'd1;
   localparam logic [1:0] KIND_SELECT = 2'd2;
   localparam logic [1:0] KIND_SYNC   = 2'd3;

   // Register indexes on the csr port
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_BYTES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_KIB   = 2'd1;

   typedef struct packed {
      logic [1:0] kind;
      logic [9:0] slot_index;
   } req_type;

   typedef struct packed {
      logic        success;
      logic [9:0]  granted_slot;
      logic [10:0] used_slots;
      logic        page_full;
      logic        page_dirty;
   } rsp_type;

   // Divider handshake back to the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

[hw/rtl/psba_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module psba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                                       clock,
   input  wire logic                                       we,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                           wdata,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

[hw/rtl/psba_div.sv]
// Restoring radix-2 divider, one quotient bit per cycle, for the slot count.
// Depends on psba_pkg (DIV_W, DIV_CNT, div_status_type).
`default_nettype none

module psba_div
   import psba_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DIV_W-1:0] dividend,
   input  wire logic [DIV_W-1:0] divisor,
   output div_status_type        status,
   output logic      [DIV_W-1:0] quotient
);

   logic [DIV_W-1:0]   rem_ff;
   logic [DIV_W-1:0]   quo_ff;
   logic [DIV_W-1:0]   dsr_ff;
   logic [DIV_CNT-1:0] cnt_ff;
   logic               busy_ff;
   logic               done_ff;
   logic [DIV_W:0]     shifted;
   logic [DIV_W:0]     trial;
   logic               take;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_W-1]};
      trial   = shifted - {1'b0, dsr_ff};
      take    = !trial[DIV_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT'(DIV_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= take ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
         quo_ff <= {quo_ff[DIV_W-2:0], take};
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

`default_nettype wire

[hw/rtl/page_slot_bitmap_allocator_top.sv]
// Page slot bitmap allocator, top level: request sequencer around the bitmap RAM.
// Depends on psba_pkg, psba_ram and psba_div.
`default_nettype none

// Keeps the occupancy bitmap of one storage page and serves insert (claim
// the lowest free slot), drop, select and sync requests, one response word
// per request word. The bitmap lives in a RAM of 32-slot words with a
// per-word valid bit and a per-word full bit in flops; a word that was
// never written since reset or the last register write reads as all free,
// so there is no clearing pass. Each request runs in steps: the accept
// edge issues the bitmap word read (for insert, the lowest non-full word
// picked from the full bits), the read-modify-write state does the
// read-modify-write and builds the response, and the done state moves it
// into the output register once that is free. A new request is taken
// while a response still waits on rsp_stall. Writing slot_bytes or
// page_kib reformats the page (map, count and dirty flag cleared) and
// recomputes the usable slot count with a bit-serial divider: requests are
// stalled while the divider starts, runs and reports done, and csr_ready
// is low meanwhile. Writes to indexes beyond the two registers are ignored.
module page_slot_bitmap_allocator_top
   import psba_pkg::*;
#(
   parameter int MAX_SLOTS = 1024
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // request channel
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_type              req_payload,
   // response channel
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_type                   rsp_payload,
   // register write channel
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_data
);

   // ---------------------------------------------------------------------
   // Sizing
   // ---------------------------------------------------------------------
   localparam int NW = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;   // map words
   localparam int AW = (NW > 1) ? $clog2(NW) : 1;                 // word address
   localparam int SW = AW + WORD_LG;                              // slot number
   localparam int UW = $clog2(MAX_SLOTS + 1);                     // counts
   localparam int XW0 = (UW > SW) ? UW : SW;
   localparam int XW  = (XW0 > 10) ? XW0 : 10;                    // compare width

   localparam int RESET_Q = ((RESET_PAGE_KIB * 1024 - HEADER_BYTES) * 8)
                            / (RESET_SLOT_BYTES * 8 + 1);
   localparam int RESET_USABLE = (RESET_Q > MAX_SLOTS) ? MAX_SLOTS : RESET_Q;

   // sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RMW  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   // ---------------------------------------------------------------------
   // Configuration and usable slot count
   // ---------------------------------------------------------------------
   logic [15:0]       slot_bytes_ff;
   logic [6:0]        page_kib_ff;
   logic [UW-1:0]     usable_ff;
   logic              div_start_ff;
   div_status_type    div_status;
   logic [DIV_W-1:0]  div_q;
   logic [DIV_W-1:0]  div_dividend;
   logic [DIV_W-1:0]  div_divisor;
   logic [16:0]       page_bytes;
   logic              csr_write;
   logic              csr_hit;

   assign csr_ready = !div_status.busy && !div_start_ff && !div_status.done;
   assign csr_write = csr_valid && csr_ready;
   assign csr_hit   = csr_write && (csr_index == CSR_SLOT_BYTES ||
                                    csr_index == CSR_PAGE_KIB);

   // (page_kib*1024 - 9) * 8, zero for an empty page
   always_comb begin
      page_bytes   = {page_kib_ff, 10'b0};
      div_dividend = (page_kib_ff == 7'd0) ? '0
                   : DIV_W'({page_bytes - 17'(HEADER_BYTES), 3'b000});
      div_divisor  = DIV_W'({slot_bytes_ff, 3'b001});
   end

   psba_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .status   (div_status),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_bytes_ff <= 16'(RESET_SLOT_BYTES);
         page_kib_ff   <= 7'(RESET_PAGE_KIB);
         usable_ff     <= UW'(RESET_USABLE);
         div_start_ff  <= 1'b0;
      end else begin
         div_start_ff <= csr_hit;
         if (csr_write && csr_index == CSR_SLOT_BYTES) begin
            slot_bytes_ff <= csr_data;
         end
         if (csr_write && csr_index == CSR_PAGE_KIB) begin
            page_kib_ff <= csr_data[6:0];
         end
         if (div_status.done) begin
            // saturate at the map size
            usable_ff <= (div_q > DIV_W'(MAX_SLOTS)) ? UW'(MAX_SLOTS) : UW'(div_q);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Request sequencer
   // ---------------------------------------------------------------------
   logic [1:0]    state_ff, state_in;
   logic [NW-1:0] valid_ff;      // word written since the last reformat
   logic [NW-1:0] full_ff;       // word has every bit set
   logic [UW-1:0] count_ff, count_in;
   logic          dirty_ff, dirty_in;
   logic [1:0]    op_kind_ff;
   logic [9:0]    op_idx_ff;
   logic [AW-1:0] op_addr_ff;
   logic          op_any_ff;     // insert found a non-full word
   rsp_type       res_ff, res_in;
   rsp_type       rsp_ff;
   logic          rsp_valid_ff;

   logic          req_take;
   logic          rsp_free;
   logic          free_any;
   logic [AW-1:0] free_word;
   logic [AW-1:0] rd_addr;
   logic [XW-1:0] req_idx_x;

   logic [WORD_BITS-1:0] ram_rdata;
   logic [WORD_BITS-1:0] word_cur;
   logic [WORD_BITS-1:0] word_new;
   logic [WORD_LG-1:0]   zero_bit;
   logic                 zero_any;
   logic [WORD_LG-1:0]   bit_sel;
   logic [XW-1:0]        slot_x;
   logic [XW-1:0]        idx_x;
   logic                 idx_in_range;
   logic                 op_ok;
   logic                 map_we;

   assign req_stall = (state_ff != ST_IDLE) || div_status.busy || div_start_ff
                      || div_status.done;
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // lowest word with a free slot
   always_comb begin
      free_any  = 1'b0;
      free_word = '0;
      for (int w = NW - 1; w >= 0; w--) begin
         if (!full_ff[w]) begin
            free_any  = 1'b1;
            free_word = AW'(w);
         end
      end
   end

   always_comb begin
      req_idx_x = XW'(req_payload.slot_index);
      rd_addr   = (req_payload.kind == KIND_INSERT) ? free_word
                                                     : req_idx_x[SW-1:WORD_LG];
   end

   psba_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (NW)
   ) u_map (
      .clock (clock),
      .we    (map_we),
      .waddr (op_addr_ff),
      .wdata (word_new),
      .raddr (rd_addr),
      .rdata (ram_rdata)
   );

   // read-modify-write of the addressed bitmap word
   always_comb begin
      word_cur = valid_ff[op_addr_ff] ? ram_rdata : '0;

      zero_any = 1'b0;
      zero_bit = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (!word_cur[b]) begin
            zero_any = 1'b1;
            zero_bit = WORD_LG'(b);
         end
      end

      idx_x        = XW'(op_idx_ff);
      idx_in_range = idx_x < XW'(usable_ff);
      slot_x       = XW'({op_addr_ff, zero_bit});
      bit_sel      = (op_kind_ff == KIND_INSERT) ? zero_bit : op_idx_ff[WORD_LG-1:0];

      word_new = word_cur;
      op_ok    = 1'b0;
      map_we   = 1'b0;
      count_in = count_ff;
      dirty_in = dirty_ff;
      unique case (op_kind_ff)
         KIND_INSERT: begin
            // first free slot overall; past the usable range means page full
            if (op_any_ff && zero_any && slot_x < XW'(usable_ff)) begin
               op_ok = 1'b1;
               word_new[bit_sel] = 1'b1;
               count_in = count_ff + 1'b1;
               dirty_in = 1'b1;
            end
         end
         KIND_DROP: begin
            if (idx_in_range && word_cur[bit_sel]) begin
               op_ok = 1'b1;
               word_new[bit_sel] = 1'b0;
               count_in = count_ff - 1'b1;
               dirty_in = 1'b1;
            end
         end
         KIND_SELECT: begin
            op_ok = idx_in_range && word_cur[bit_sel];
         end
         KIND_SYNC: begin
            op_ok    = 1'b1;
            dirty_in = 1'b0;
         end
      endcase
      map_we = (state_ff == ST_RMW) && op_ok &&
               (op_kind_ff == KIND_INSERT || op_kind_ff == KIND_DROP);

      res_in.success      = op_ok;
      res_in.granted_slot = (op_kind_ff == KIND_INSERT && op_ok) ? 10'(slot_x) : op_idx_ff;
      res_in.used_slots   = 11'(count_in);
      res_in.page_full    = count_in >= usable_ff;
      res_in.page_dirty   = dirty_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_take) begin
            state_in = ST_RMW;
         end
         ST_RMW:  state_in = ST_DONE;
         ST_DONE: if (rsp_free) begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         full_ff      <= '0;
         count_ff     <= '0;
         dirty_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_hit) begin
            // reformat the page
            valid_ff <= '0;
            full_ff  <= '0;
            count_ff <= '0;
            dirty_ff <= 1'b0;
         end else if (state_ff == ST_RMW) begin
            count_ff <= count_in;
            dirty_ff <= dirty_in;
            if (map_we) begin
               valid_ff[op_addr_ff] <= 1'b1;
               full_ff[op_addr_ff]  <= &word_new;
            end
         end
         if (state_ff == ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         op_kind_ff <= req_payload.kind;
         op_idx_ff  <= req_payload.slot_index;
         op_addr_ff <= rd_addr;
         op_any_ff  <= free_any;
      end
      if (state_ff == ST_RMW) begin
         res_ff <= res_in;
      end
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= usable_ff)
      else $error("occupied count above usable slot count");

   a_take_to_rmw: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == ST_RMW)
      else $error("accepted request did not enter read-modify-write");

   a_reformat: assert property (@(posedge clock) disable iff (reset)
      csr_hit |=> (count_ff == '0) && !dirty_ff && (valid_ff == '0))
      else $error("register write did not reformat the page");

   a_no_take_while_div: assert property (@(posedge clock) disable iff (reset)
      div_status.busy |-> state_ff == ST_IDLE)
      else $error("request in flight while slot count recomputes");

endmodule

`default_nettype wire

[tb/sv/page_slot_bitmap_allocator_top_tb.sv]
// Self-checking testbench for page_slot_bitmap_allocator_top: directed and random
// request words checked against an in-bench model of the page bitmap.
// Depends on psba_pkg and the allocator RTL only.

module page_slot_bitmap_allocator_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import psba_pkg::*;

   localparam int MAP_SLOTS    = 1024;
   localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
   localparam int QUIET_LIMIT  = 4000;  // cycles with no handshake before giving up
   localparam int DRAIN_CYCLES = 20;
   localparam int REPORT_MAX   = 10;

   // register indexes past the two real registers; writes there do nothing
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_stall;
   req_type              req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_stall   = 1'b0;
   rsp_type              rsp_payload;
   logic                 csr_valid   = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index   = '0;
   logic [CSR_DAT_W-1:0] csr_data    = '0;

   page_slot_bitmap_allocator_top #(
      .MAX_SLOTS(MAP_SLOTS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Page model: occupancy map, count, dirty flag and the two registers
   // ------------------------------------------------------------------
   bit          slot_taken [MAP_SLOTS];
   int unsigned taken_count;
   int unsigned usable_count;
   bit          map_dirty;
   int unsigned slot_bytes_reg = RESET_SLOT_BYTES;
   int unsigned page_kib_reg   = RESET_PAGE_KIB;

   rsp_type     pending_rsp [$];   // responses owed, oldest first
   int unsigned mismatches = 0;

   // per-slot cost is slot_bytes*8+1 bits after the header; capped at the map size
   function automatic int unsigned slots_per_page(int unsigned sb, int unsigned pk);
      longint unsigned page_bytes;
      longint unsigned bits_per_slot;
      longint unsigned n;
      page_bytes    = longint'(pk) * 1024;
      bits_per_slot = longint'(sb) * 8 + 1;
      if (page_bytes <= HEADER_BYTES)
         return 0;
      n = ((page_bytes - HEADER_BYTES) * 8) / bits_per_slot;
      if (n > MAP_SLOTS)
         n = MAP_SLOTS;
      return int'(n);
   endfunction

   // reformat: map, count and dirty flag cleared, slot count recomputed
   function automatic void format_page();
      foreach (slot_taken[i])
         slot_taken[i] = 1'b0;
      taken_count  = 0;
      map_dirty    = 1'b0;
      usable_count = slots_per_page(slot_bytes_reg, page_kib_reg);
   endfunction

   function automatic rsp_type slot_map_predict(req_type r);
      rsp_type     o;
      int unsigned i;
      o.success      = 1'b0;
      o.granted_slot = r.slot_index;
      case (r.kind)
         KIND_INSERT: begin
            // lowest free usable slot; nothing changes on a full page
            for (i = 0; i < usable_count && !o.success; i++) begin
               if (!slot_taken[i]) begin
                  slot_taken[i]  = 1'b1;
                  taken_count++;
                  map_dirty      = 1'b1;
                  o.granted_slot = i[9:0];
                  o.success      = 1'b1;
               end
            end
         end
         KIND_DROP: begin
            if (r.slot_index < usable_count && slot_taken[r.slot_index]) begin
               slot_taken[r.slot_index] = 1'b0;
               taken_count--;
               map_dirty = 1'b1;
               o.success = 1'b1;
            end
         end
         KIND_SELECT: begin
            if (r.slot_index < usable_count && slot_taken[r.slot_index])
               o.success = 1'b1;
         end
         KIND_SYNC: begin
            map_dirty = 1'b0;
            o.success = 1'b1;
         end
      endcase
      o.used_slots = taken_count[10:0];
      o.page_full  = (taken_count >= usable_count);
      o.page_dirty = map_dirty;
      return o;
   endfunction

   function automatic void flag_error(string msg);
      mismatches++;
      if (mismatches <= REPORT_MAX)
         $display("ERROR: %s", msg);
   endfunction

   // ------------------------------------------------------------------
   // Request side: every accepted request word updates the model and
   // queues the response it owes.  Sampled at the edge, before the
   // nonblocking updates of that edge land.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         pending_rsp.insert(pending_rsp.size(), slot_map_predict(req_payload));
   end

   // ------------------------------------------------------------------
   // Response side: each accepted response word against the oldest owed one
   // ------------------------------------------------------------------
   rsp_type rsp_want;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            flag_error($sformatf("response word with none owed: %p", rsp_payload));
         end else begin
            rsp_want = pending_rsp.pop_front();
            if (rsp_payload.success      !== rsp_want.success      ||
                rsp_payload.granted_slot !== rsp_want.granted_slot ||
                rsp_payload.used_slots   !== rsp_want.used_slots   ||
                rsp_payload.page_full    !== rsp_want.page_full    ||
                rsp_payload.page_dirty   !== rsp_want.page_dirty)
               flag_error($sformatf(
                  "rsp ok/slot/used/full/dirty got %b/%0d/%0d/%b/%b want %b/%0d/%0d/%b/%b",
                  rsp_payload.success, rsp_payload.granted_slot, rsp_payload.used_slots,
                  rsp_payload.page_full, rsp_payload.page_dirty,
                  rsp_want.success, rsp_want.granted_slot, rsp_want.used_slots,
                  rsp_want.page_full, rsp_want.page_dirty));
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver stall: random, or held high through the hold_left countdown when a test asks
   // (hold_asked is bumped by the test, served here; single writer each).
   // ------------------------------------------------------------------
   int req_idle_pct  = 35;
   int rsp_stall_pct = 35;
   int hold_asked    = 0;
   int hold_served   = 0;
   int hold_left     = 0;

   always @(posedge clock) begin
      if (hold_served != hold_asked) begin
         hold_served <= hold_asked;
         hold_left   <= HOLD_CYCLES;
         rsp_stall   <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Watchdog: any stretch with no handshake on any channel that is too long
   int unsigned quiet_cycles = 0;

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
         $display("page_slot_bitmap_allocator_top_tb NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------

   // Offer one request word and return at the edge that takes it.  Valid
   // stays high so a following word goes out back to back; callers that
   // stop sending lower it in the same step.
   task automatic send_req(logic [1:0] kind, logic [9:0] idx);
      req_type r;
      r.kind       = kind;
      r.slot_index = idx;
      if ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // Mostly slots near the usable range so drops and selects hit; some
   // anywhere in the 10-bit field.
   task automatic send_random(int unsigned span, int ins_pct, int drop_pct, int sel_pct);
      int          pick;
      logic [1:0]  kind;
      logic [9:0]  idx;
      pick = $urandom_range(99);
      if (pick < ins_pct)
         kind = KIND_INSERT;
      else if (pick < ins_pct + drop_pct)
         kind = KIND_DROP;
      else if (pick < ins_pct + drop_pct + sel_pct)
         kind = KIND_SELECT;
      else
         kind = KIND_SYNC;
      if ($urandom_range(99) < 85)
         idx = 10'($urandom_range(span > 1023 ? 1023 : span));
      else
         idx = 10'($urandom_range(1023));
      send_req(kind, idx);
   endtask

   // Register write, only once every owed response is back.  One edge
   // first so the word taken at the last edge is already queued.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] data);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0)
         @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_SLOT_BYTES) begin
         slot_bytes_reg = data;
         format_page();
      end else if (idx == CSR_PAGE_KIB) begin
         page_kib_reg = data[6:0];
         format_page();
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset layout: 64 KiB page of 64-byte slots, 1021 usable.
   task automatic test_reset_layout();
      send_req(KIND_SELECT, 10'd0);      // empty map
      send_req(KIND_DROP, 10'd0);        // drop of a free slot
      send_req(KIND_INSERT, 10'h3FF);    // slot_index ignored on insert
      send_req(KIND_INSERT, 10'h000);
      send_req(KIND_SELECT, 10'd1);
      send_req(KIND_SELECT, 10'd1021);   // first slot past the usable range
      send_req(KIND_DROP, 10'd1);
      send_req(KIND_DROP, 10'd1);        // second drop fails
      send_req(KIND_SYNC, 10'h2AA);
      send_req(KIND_INSERT, 10'h155);    // refills the hole at 1
   endtask

   // Writes past the register list leave the page as it is.
   task automatic test_spare_registers();
      write_reg(CSR_SPARE_A, 16'($urandom_range(65535)));
      write_reg(CSR_SPARE_B, 16'hFFFF);
      send_req(KIND_SELECT, 10'd0);
   endtask

   // Layouts with no usable slot: the page is full from the start.
   task automatic test_empty_page();
      write_reg(CSR_SLOT_BYTES, 16'hFFFF);
      send_req(KIND_INSERT, 10'h3FF);
      send_req(KIND_DROP, 10'd0);
      send_req(KIND_SELECT, 10'd0);
      send_req(KIND_SYNC, 10'd0);
      write_reg(CSR_SLOT_BYTES, 16'd0);
      write_reg(CSR_PAGE_KIB, 16'd0);    // page no bigger than the header
      send_req(KIND_INSERT, 10'd5);
   endtask

   // Seven slots: fill, insert on a full page, out-of-range access, refill.
   task automatic test_small_page();
      write_reg(CSR_SLOT_BYTES, 16'd127);
      write_reg(CSR_PAGE_KIB, 16'd1);
      repeat (8)
         send_req(KIND_INSERT, 10'($urandom_range(1023)));
      send_req(KIND_SELECT, 10'd6);
      send_req(KIND_SELECT, 10'd7);
      send_req(KIND_DROP, 10'd7);
      send_req(KIND_DROP, 10'd3);
      send_req(KIND_INSERT, 10'd0);
   endtask

   // Several layouts, small and large register values among them, random mix.
   task automatic test_random_layouts();
      int unsigned sb [5];
      int unsigned pk [5];
      sb = '{1, 127, 2000, $urandom_range(16, 400), $urandom_range(65535)};
      pk = '{1, 1, 64, $urandom_range(1, 8), $urandom_range(127)};
      foreach (sb[p]) begin
         write_reg(CSR_SLOT_BYTES, 16'(sb[p]));
         // upper data bits are don't-care for page_kib
         write_reg(CSR_PAGE_KIB, 16'(($urandom_range(511) << 7) | pk[p]));
         repeat (100)
            send_random(usable_count + 1, 40, 25, 25);
      end
   endtask

   // Receiver holds off while the sender keeps offering: the block backs up.
   task automatic test_backpressure();
      write_reg(CSR_SLOT_BYTES, 16'd200);
      write_reg(CSR_PAGE_KIB, 16'd2);
      req_idle_pct = 0;
      hold_asked   = hold_asked + 1;
      repeat (40)
         send_random(usable_count + 1, 50, 20, 20);
      req_idle_pct = 35;
   endtask

   // 1024-slot map filled to the top; first 500 requests with no idling on either side.
   task automatic test_full_map();
      write_reg(CSR_SLOT_BYTES, 16'd0);
      write_reg(CSR_PAGE_KIB, 16'hFFFF);
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      repeat (500)
         send_random(1023, 95, 3, 1);
      req_idle_pct  = 35;
      rsp_stall_pct = 35;
      repeat (650)
         send_random(1023, 95, 3, 1);
   endtask

   initial begin
      format_page();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_reset_layout();
      test_spare_registers();
      test_empty_page();
      test_small_page();
      test_random_layouts();
      test_backpressure();
      test_full_map();

      // stop offering, collect the tail, then give the block time to
      // show any response word nobody asked for
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_rsp.size() != 0)
         flag_error($sformatf("%0d response words never arrived", pending_rsp.size()));

      if (mismatches == 0)
         $display("page_slot_bitmap_allocator_top_tb OK");
      else
         $display("page_slot_bitmap_allocator_top_tb NOT OK");
      $finish;
   end

endmodule
